@@ rtl/rppm_pkg.sv @@
// Shared types and constants for the redundant path packet merger.
// No dependencies; imported by every module of the block except rppm_ram.
package rppm_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int SLOT_W     = $clog2(RING_DEPTH);
    localparam int SIZE_W     = SLOT_W + 1;
    localparam int TIME_W     = 63;
    localparam int SEQ_W      = 32;
    localparam int DELAY_W    = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_CNT_W  = $clog2(SEQ_W);

    localparam logic [CFG_IDX_W-1:0] CFG_RING_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATH_DELAY = 2'd1;

    localparam logic [SIZE_W-1:0]  RING_SIZE_RST  = SIZE_W'(RING_DEPTH);
    localparam logic [DELAY_W-1:0] PATH_DELAY_RST = DELAY_W'(1000);

    typedef enum logic [1:0] {
        MODE_WAIT_FIRST = 2'd0,
        MODE_RUNNING    = 2'd1,
        MODE_WAITING    = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, A_DIV, A_RD, A_EV, P_RD, P_EV, P_RRD, P_REV, P_EMIT
    } t_state;

    // one ring slot as stored in memory
    typedef struct packed {
        logic              valid;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] arrival;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    // controller to datapath
    typedef struct packed {
        logic cap;
        logic clr_wr;
        logic div_init;
        logic div_step;
        logic arr_mode;
        logic rd_idx;
        logic arr_wr;
        logic poll_init;
        logic rd_cur;
        logic scan_adv;
        logic set_wait;
        logic set_nrt;
        logic rel_first;
        logic rel_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic func;
        logic hdr_ok;
        logic clr_last;
        logic div_last;
        logic running;
        logic nrt_young;
        logic slot_valid;
        logic slot_young;
        logic scan_full;
        logic wrap;
        logic out_free;
    } t_stat;

endpackage

@@ rtl/rppm_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rppm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/rppm_ctrl.sv @@
// Controller state machine for the packet merger: sequences clear, arrival and poll.
// Depends on rppm_pkg.
module rppm_ctrl import rppm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (i_stat.clr_last) n_state = S_IDLE;
            S_IDLE: if (i_valid) n_state = S_DISP;
            S_DISP: begin
                if (!i_stat.func) begin
                    n_state = i_stat.hdr_ok ? A_DIV : S_IDLE;
                end else if (!i_stat.running || i_stat.nrt_young) begin
                    n_state = P_EMIT;
                end else begin
                    n_state = P_RD;
                end
            end
            A_DIV:  if (i_stat.div_last) n_state = A_RD;
            A_RD:   n_state = A_EV;
            A_EV:   n_state = S_IDLE;
            P_RD:   n_state = P_EV;
            P_EV: begin
                if (i_stat.slot_valid) begin
                    if (i_stat.slot_young || i_stat.wrap) n_state = P_EMIT;
                    else n_state = P_RRD;
                end else if (i_stat.scan_full) begin
                    n_state = P_EMIT;
                end else begin
                    n_state = P_RD;
                end
            end
            P_RRD:  n_state = P_REV;
            P_REV: begin
                if (i_stat.slot_valid && !i_stat.slot_young && !i_stat.wrap) n_state = P_RRD;
                else n_state = P_EMIT;
            end
            P_EMIT: if (i_stat.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLR:  o_cmd.clr_wr = 1'b1;
            S_IDLE: begin
                o_ready   = 1'b1;
                o_cmd.cap = i_valid;
            end
            S_DISP: begin
                o_cmd.div_init  = !i_stat.func && i_stat.hdr_ok;
                o_cmd.poll_init = i_stat.func && i_stat.running && !i_stat.nrt_young;
            end
            A_DIV:  o_cmd.div_step = 1'b1;
            A_RD: begin
                o_cmd.arr_mode = 1'b1;
                o_cmd.rd_idx   = 1'b1;
            end
            A_EV:   o_cmd.arr_wr = !i_stat.slot_valid;
            P_RD:   o_cmd.rd_cur = 1'b1;
            P_EV: begin
                if (i_stat.slot_valid) begin
                    o_cmd.set_nrt   = i_stat.slot_young;
                    o_cmd.rel_first = !i_stat.slot_young;
                    o_cmd.rel_step  = !i_stat.slot_young;
                end else begin
                    o_cmd.set_wait = i_stat.scan_full;
                    o_cmd.scan_adv = !i_stat.scan_full;
                end
            end
            P_RRD:  o_cmd.rd_cur = 1'b1;
            P_REV:  o_cmd.rel_step = i_stat.slot_valid && !i_stat.slot_young;
            P_EMIT: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule

@@ rtl/rppm_dp.sv @@
// Datapath for the packet merger: slot ring, modulo unit, pointers and result register.
// Depends on rppm_pkg and rppm_ram.
module rppm_dp import rppm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_func,
    input  logic [TIME_W-1:0]    i_now_ns,
    input  logic [SEQ_W-1:0]     i_seq_number,
    input  logic                 i_header_ok,
    input  logic [TIME_W-1:0]    i_hw_stamp,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [SIZE_W-1:0]    o_release_count,
    output logic [SLOT_W-1:0]    o_start_slot,
    output logic [SEQ_W-1:0]     o_first_seq,
    output logic [TIME_W-1:0]    o_first_stamp,
    output logic [TIME_W-1:0]    o_last_stamp,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat
);
    logic [SIZE_W-1:0]    r_ring_size;
    logic [DELAY_W-1:0]   r_path_delay;
    logic                 r_func, r_hdr;
    logic [TIME_W-1:0]    r_now, r_stamp, r_nrt;
    logic [SEQ_W-1:0]     r_seq, r_quo;
    logic [SIZE_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [SLOT_W-1:0]    r_read_slot, r_cur, r_clr;
    logic [SIZE_W-1:0]    r_n, r_chunk;
    t_mode                r_mode;
    logic [SLOT_W-1:0]    r_w_start;
    logic [SEQ_W-1:0]     r_w_seq;
    logic [TIME_W-1:0]    r_w_fst, r_w_lst;

    logic [SIZE_W-1:0]    size_eff;
    logic [SIZE_W:0]      div_t;
    logic [SLOT_W-1:0]    idx, next_cur, waddr, raddr;
    logic                 wrap, we;
    t_slot                wdata, rdata;

    // clamp ring size to 1..RING_DEPTH
    always_comb begin
        if (r_ring_size == '0) size_eff = SIZE_W'(1);
        else if (r_ring_size > SIZE_W'(RING_DEPTH)) size_eff = SIZE_W'(RING_DEPTH);
        else size_eff = r_ring_size;
    end

    assign idx      = r_rem[SLOT_W-1:0];
    assign div_t    = {r_rem, r_quo[SEQ_W-1]};
    assign wrap     = ({1'b0, r_cur} + SIZE_W'(1)) >= size_eff;
    assign next_cur = wrap ? '0 : r_cur + SLOT_W'(1);

    // ring memory ports
    always_comb begin
        we    = i_cmd.clr_wr || i_cmd.arr_wr || i_cmd.rel_step;
        waddr = i_cmd.clr_wr ? r_clr : (i_cmd.arr_wr ? idx : r_cur);
        wdata = '0;
        if (i_cmd.arr_wr) begin
            wdata.valid   = 1'b1;
            wdata.seq     = r_seq;
            wdata.stamp   = r_stamp;
            wdata.arrival = r_now;
        end
        raddr = i_cmd.rd_idx ? idx : r_cur;
    end

    rppm_ram #(.WIDTH(SLOT_BITS), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // status back to the controller
    always_comb begin
        o_stat.func       = r_func;
        o_stat.hdr_ok     = r_hdr;
        o_stat.clr_last   = r_clr == SLOT_W'(RING_DEPTH - 1);
        o_stat.div_last   = r_div_cnt == DIV_CNT_W'(SEQ_W - 1);
        o_stat.running    = r_mode == MODE_RUNNING;
        o_stat.nrt_young  = ({1'b0, r_nrt} + {32'd0, r_path_delay}) >= {1'b0, r_now};
        o_stat.slot_valid = rdata.valid;
        o_stat.slot_young = ({1'b0, rdata.arrival} + {32'd0, r_path_delay}) >= {1'b0, r_now};
        o_stat.scan_full  = (r_n + SIZE_W'(1)) == size_eff;
        o_stat.wrap       = wrap;
        o_stat.out_free   = !o_valid || i_ready;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_size  <= RING_SIZE_RST;
            r_path_delay <= PATH_DELAY_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_RING_SIZE) r_ring_size <= i_cfg_data[SIZE_W-1:0];
            if (i_cfg_idx == CFG_PATH_DELAY) r_path_delay <= i_cfg_data[DELAY_W-1:0];
        end
    end

    // merge control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT_FIRST;
            r_read_slot <= '0;
            r_nrt       <= '0;
            r_clr       <= '0;
            o_valid     <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) r_clr <= r_clr + SLOT_W'(1);
            if (i_cmd.arr_mode && r_mode != MODE_RUNNING) begin
                if (r_mode == MODE_WAIT_FIRST) r_read_slot <= idx;
                r_mode <= MODE_RUNNING;
                r_nrt  <= r_now;
            end
            if (i_cmd.poll_init && {1'b0, r_read_slot} >= size_eff) r_read_slot <= '0;
            if (i_cmd.set_wait) r_mode <= MODE_WAITING;
            if (i_cmd.set_nrt) r_nrt <= rdata.arrival;
            if (i_cmd.rel_step) r_read_slot <= next_cur;
            if (i_cmd.out_load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // capture, modulo unit, scan pointer and working result
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_func    <= i_func;
            r_now     <= i_now_ns;
            r_seq     <= i_seq_number;
            r_hdr     <= i_header_ok;
            r_stamp   <= i_hw_stamp;
            r_chunk   <= '0;
            r_w_start <= '0;
            r_w_seq   <= '0;
            r_w_fst   <= '0;
            r_w_lst   <= '0;
        end
        if (i_cmd.div_init) begin
            r_rem     <= '0;
            r_quo     <= r_seq;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= (div_t >= {1'b0, size_eff}) ? SIZE_W'(div_t - {1'b0, size_eff})
                                                     : div_t[SIZE_W-1:0];
            r_quo     <= {r_quo[SEQ_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.poll_init) begin
            r_cur <= ({1'b0, r_read_slot} >= size_eff) ? '0 : r_read_slot;
            r_n   <= '0;
        end
        if (i_cmd.scan_adv) begin
            r_cur <= next_cur;
            r_n   <= r_n + SIZE_W'(1);
        end
        if (i_cmd.rel_first) begin
            r_w_start <= r_cur;
            r_w_seq   <= rdata.seq;
            r_w_fst   <= rdata.stamp;
        end
        if (i_cmd.rel_step) begin
            r_w_lst <= rdata.stamp;
            r_chunk <= r_chunk + SIZE_W'(1);
            r_cur   <= next_cur;
        end
        if (i_cmd.out_load) begin
            o_release_count <= r_chunk;
            o_start_slot    <= r_w_start;
            o_first_seq     <= r_w_seq;
            o_first_stamp   <= r_w_fst;
            o_last_stamp    <= r_w_lst;
        end
    end
endmodule

@@ rtl/redundant_path_packet_merger_unit.sv @@
// Top level of the redundant path packet merger: controller plus datapath.
// Depends on rppm_pkg, rppm_ctrl, rppm_dp.

// After reset the block sweeps its 4096-slot ring to clear the valid bits and
// holds o_ready low meanwhile. Items are handled one at a time. A packet with a
// bad header goes back to idle from dispatch; a good arrival runs the bit-serial
// sequence-number modulo (32 steps) and then one slot read, with a write only
// when the slot is empty. Each ring slot a poll reads (gap slots skipped and
// slots released) is read through the registered memory port before it is
// tested. The poll result sits in an output register, so the next item is taken
// while the result waits; a later poll then holds in its emit state until that
// register has been read.
module redundant_path_packet_merger_unit import rppm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_func,
    input  logic [TIME_W-1:0]    i_now_ns,
    input  logic [SEQ_W-1:0]     i_seq_number,
    input  logic                 i_header_ok,
    input  logic [TIME_W-1:0]    i_hw_stamp,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [SIZE_W-1:0]    o_release_count,
    output logic [SLOT_W-1:0]    o_start_slot,
    output logic [SEQ_W-1:0]     o_first_seq,
    output logic [TIME_W-1:0]    o_first_stamp,
    output logic [TIME_W-1:0]    o_last_stamp
);
    t_cmd  cmd;
    t_stat stat;

    rppm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rppm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_now_ns        (i_now_ns),
        .i_seq_number    (i_seq_number),
        .i_header_ok     (i_header_ok),
        .i_hw_stamp      (i_hw_stamp),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_release_count (o_release_count),
        .o_start_slot    (o_start_slot),
        .o_first_seq     (o_first_seq),
        .o_first_stamp   (o_first_stamp),
        .o_last_stamp    (o_last_stamp),
        .i_cmd           (cmd),
        .o_stat          (stat)
    );
endmodule

@@ rtl/rppm_checker.sv @@
// Port-level checks for the packet merger top level, attached by bind.
// Depends on rppm_pkg and redundant_path_packet_merger_unit.
module rppm_checker import rppm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [SIZE_W-1:0] o_release_count,
    input logic [SLOT_W-1:0] o_start_slot,
    input logic [SEQ_W-1:0]  o_first_seq
);
    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_release_count))
        else $error("result changed while stalled");

    // never release more than the ring holds
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_release_count <= SIZE_W'(RING_DEPTH))
        else $error("release count larger than ring");

    // an empty release carries zero fields
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_release_count == '0 |-> o_start_slot == '0 && o_first_seq == '0)
        else $error("empty release with nonzero fields");

    // accept nothing right after reset is released, when the ring clear begins
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_ready)
        else $error("ready during ring clear");
endmodule

bind redundant_path_packet_merger_unit rppm_checker u_rppm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_release_count (o_release_count),
    .o_start_slot    (o_start_slot),
    .o_first_seq     (o_first_seq)
);
